### design/iirdf1_pkg.sv
// Shared types, widths and register codes for the fourth-order direct form I IIR filter.
// Depends on nothing; every other file of the filter but iirdf1_checker imports it.
package iirdf1_pkg;

  localparam int MAX_ORDER      = 4;
  localparam int SMP_W          = 16;
  localparam int COEF_W         = 16;
  localparam int OUT_W          = 24;
  localparam int ACC_W          = 44;
  localparam int COEF_FRAC_BITS = 13;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 3;

  typedef logic signed [SMP_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0]  out_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0_1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_2_3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_4   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_3_4 = 3'd4;

  // Default band-pass coefficients in Q3.13.
  localparam logic [CFG_W-1:0] RST_FF_COEF_0_1 = 32'd1659;
  localparam logic [CFG_W-1:0] RST_FF_COEF_2_3 = 32'd62218;
  localparam logic [COEF_W-1:0] RST_FF_COEF_4  = 16'd1659;
  localparam logic [CFG_W-1:0] RST_FB_COEF_1_2 = 32'd1040954482;
  localparam logic [CFG_W-1:0] RST_FB_COEF_3_4 = 32'd106555180;

  localparam out_t OUT_MAX = 24'sh7FFFFF;
  localparam out_t OUT_MIN = 24'sh800000;
  localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(2 ** (COEF_FRAC_BITS - 1));

  // Controls that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic step;
    logic clear;
  } step_ctl_t;

  // Round half up, scale down by the coefficient fraction, saturate to the output width.
  function automatic out_t round_sat(input acc_t acc);
    logic signed [ACC_W:0] biased;
    logic signed [ACC_W:0] q;
    out_t r;
    biased = {acc[ACC_W-1], acc} + RND_BIAS;
    q = biased >>> COEF_FRAC_BITS;
    if ((&q[ACC_W:OUT_W-1]) || !(|q[ACC_W:OUT_W-1])) begin
      r = q[OUT_W-1:0];
    end else if (q[ACC_W]) begin
      r = OUT_MIN;
    end else begin
      r = OUT_MAX;
    end
    return r;
  endfunction

endpackage

### design/iirdf1_channels.sv
// Valid/ready channel interfaces for the filter: sample input and filtered output.
// Depends on iirdf1_pkg for the payload widths.
interface iirdf1_sample_if;
  import iirdf1_pkg::*;
  logic    valid;
  logic    ready;
  logic    kind;
  sample_t sample_in;
  modport source (output valid, output kind, output sample_in, input ready);
  modport sink (input valid, input kind, input sample_in, output ready);
endinterface

interface iirdf1_result_if;
  import iirdf1_pkg::*;
  logic valid;
  logic ready;
  out_t filtered_out;
  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface

### design/iir_direct_form_one_filter_unit.sv
// Top level of the fourth-order direct form I IIR filter with its coefficient registers.
// Depends on iirdf1_pkg, the channel interfaces, iirdf1_cell and iirdf1_skid.
//
//   channel    direction  payload                    transaction when
//   samples    in         kind, sample_in            valid && ready
//   results    out        filtered_out               valid && ready
//   cfg        in         cfg_index, cfg_data        cfg_write
//
// The block accepts one transaction per clock cycle while samples.ready is high. A
// sample's result is registered and shows on the result channel in the cycle after
// the sample is accepted if no earlier result waits. The cycle is set by the
// feedback loop: output history, feedback multiplier, the partial-sum adds down the
// chain of cells, rounding and saturation, back into the first cell's output history.
// Synchronous reset clears both histories and the output queue and loads the default
// band-pass coefficients. A two-entry output queue lets samples flow while a result
// waits; samples.ready falls only when both entries are taken.
module iir_direct_form_one_filter_unit #(
  parameter int ORDER = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  iirdf1_sample_if.sink                       samples,
  iirdf1_result_if.source                     results,
  input  logic                                cfg_write,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iirdf1_pkg::CFG_W-1:0]        cfg_data
);
  import iirdf1_pkg::*;

  // Coefficient registers, packed two to a word as the register map defines them.
  logic [CFG_W-1:0]  ff_coef_0_1;
  logic [CFG_W-1:0]  ff_coef_2_3;
  logic [COEF_W-1:0] ff_coef_4;
  logic [CFG_W-1:0]  fb_coef_1_2;
  logic [CFG_W-1:0]  fb_coef_3_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_coef_0_1 <= RST_FF_COEF_0_1;
      ff_coef_2_3 <= RST_FF_COEF_2_3;
      ff_coef_4   <= RST_FF_COEF_4;
      fb_coef_1_2 <= RST_FB_COEF_1_2;
      fb_coef_3_4 <= RST_FB_COEF_3_4;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FF_COEF_0_1: ff_coef_0_1 <= cfg_data;
        REG_FF_COEF_2_3: ff_coef_2_3 <= cfg_data;
        REG_FF_COEF_4:   ff_coef_4   <= cfg_data[COEF_W-1:0];
        REG_FB_COEF_1_2: fb_coef_1_2 <= cfg_data;
        REG_FB_COEF_3_4: fb_coef_3_4 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Unpack the coefficients into per-tap views.
  coef_t ff [0:MAX_ORDER];
  coef_t fb [1:MAX_ORDER];

  assign ff[0] = coef_t'(ff_coef_0_1[COEF_W-1:0]);
  assign ff[1] = coef_t'(ff_coef_0_1[CFG_W-1:COEF_W]);
  assign ff[2] = coef_t'(ff_coef_2_3[COEF_W-1:0]);
  assign ff[3] = coef_t'(ff_coef_2_3[CFG_W-1:COEF_W]);
  assign ff[4] = coef_t'(ff_coef_4);
  assign fb[1] = coef_t'(fb_coef_1_2[COEF_W-1:0]);
  assign fb[2] = coef_t'(fb_coef_1_2[CFG_W-1:COEF_W]);
  assign fb[3] = coef_t'(fb_coef_3_4[COEF_W-1:0]);
  assign fb[4] = coef_t'(fb_coef_3_4[CFG_W-1:COEF_W]);

  // Handshake. The queue has room for a result whenever samples.ready is high, so a
  // clear transaction and a sample transaction are both taken under the same rule.
  logic      has_room;
  logic      accept;
  step_ctl_t ctl;

  assign samples.ready = has_room;
  assign accept        = samples.valid && samples.ready;
  assign ctl.step      = accept && !samples.kind;
  assign ctl.clear     = accept && samples.kind;

  // Cell k holds x[n-k] and y[n-k] and hands them to cell k+1 on every sample. The
  // histories hold raw samples, so a coefficient write takes effect on the next sample
  // over the whole history.
  out_t    y;
  sample_t x_chain [0:ORDER];
  out_t    y_chain [0:ORDER];
  acc_t    s_chain [1:ORDER+1];

  assign x_chain[0]       = samples.sample_in;
  assign y_chain[0]       = y;
  assign s_chain[ORDER+1] = '0;

  for (genvar k = 1; k <= ORDER; k++) begin : g_tap
    iirdf1_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .x_in  (x_chain[k-1]),
      .y_in  (y_chain[k-1]),
      .b     (ff[k]),
      .a     (fb[k]),
      .s_in  (s_chain[k+1]),
      .x_out (x_chain[k]),
      .y_out (y_chain[k]),
      .s_out (s_chain[k])
    );
  end

  // Head of the chain: current input times b[0] plus the sum over all taps.
  logic signed [SMP_W+COEF_W-1:0] b0x;
  acc_t                           acc;

  assign b0x = ff[0] * samples.sample_in;
  assign acc = ACC_W'(b0x) + s_chain[1];
  assign y   = round_sat(acc);

  iirdf1_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (ctl.step),
    .push_data (y),
    .has_room  (has_room),
    .results   (results)
  );

endmodule

### design/iirdf1_cell.sv
// One tap of the direct form I chain of the filter: delayed input, delayed output, products.
// Depends on iirdf1_pkg.
module iirdf1_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  iirdf1_pkg::step_ctl_t ctl,
  input  iirdf1_pkg::sample_t   x_in,
  input  iirdf1_pkg::out_t      y_in,
  input  iirdf1_pkg::coef_t     b,
  input  iirdf1_pkg::coef_t     a,
  input  iirdf1_pkg::acc_t      s_in,
  output iirdf1_pkg::sample_t   x_out,
  output iirdf1_pkg::out_t      y_out,
  output iirdf1_pkg::acc_t      s_out
);
  import iirdf1_pkg::*;

  // x_hist and y_hist hold this tap's delayed input and output sample.
  sample_t                          x_hist;
  out_t                             y_hist;
  logic signed [SMP_W+COEF_W-1:0]   bx;
  logic signed [OUT_W+COEF_W-1:0]   ay;

  assign bx    = b * x_hist;
  assign ay    = a * y_hist;
  assign x_out = x_hist;
  assign y_out = y_hist;
  assign s_out = s_in + (ACC_W'(bx) - ACC_W'(ay));

  always_ff @(posedge clk) begin
    if (rst) begin
      x_hist <= '0;
      y_hist <= '0;
    end else if (ctl.clear) begin
      x_hist <= '0;
      y_hist <= '0;
    end else if (ctl.step) begin
      x_hist <= x_in;
      y_hist <= y_in;
    end
  end

endmodule

### design/iirdf1_skid.sv
// Two-entry output queue that drives the result channel of the filter.
// Depends on iirdf1_pkg and the result channel interface.
module iirdf1_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  iirdf1_pkg::out_t     push_data,
  output logic                 has_room,
  iirdf1_result_if.source      results
);
  import iirdf1_pkg::*;

  logic [1:0] count;
  out_t       head;
  out_t       tail;
  logic       pop;

  assign has_room             = (count != 2'd2);
  assign results.valid        = (count != 2'd0);
  assign results.filtered_out = head;
  assign pop                  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (count == 2'd0) begin
            head <= push_data;
          end else begin
            tail <= push_data;
          end
          count <= count + 2'd1;
        end
        2'b01: begin
          head  <= tail;
          count <= count - 2'd1;
        end
        2'b11: begin
          if (count == 2'd1) begin
            head <= push_data;
          end else begin
            head <= tail;
            tail <= push_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/iirdf1_checker.sv
// Port-level assertions for the IIR filter top level, and the bind that attaches them.
// Depends on iir_direct_form_one_filter_unit and its channel interfaces.
module iirdf1_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready,
  input logic [23:0] out_data
);

  // The output queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result channel valid right after reset");

  // An accepted sample always leaves a result in the queue.
  a_sample_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_kind |=> out_valid)
    else $error("accepted sample produced no result");

  // A clear transaction taken with the queue empty never creates a result.
  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind && !out_valid |=> !out_valid)
    else $error("clear transaction produced a result");

  // Input back-pressure only comes from results waiting in the queue.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("samples stalled with no result pending");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind iir_direct_form_one_filter_unit iirdf1_checker u_iirdf1_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_kind   (samples.kind),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.filtered_out)
);

### tb/filter_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the direct form I filter bench: a bit-true predictor of the filter,
// its own copy of the coefficient registers and histories, and the queue of due outputs.
// Depends on iirdf1_pkg for widths, register indexes and default coefficients.
package filter_check_pkg;
  import iirdf1_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam int unsigned REPORT_LIMIT = 200;

  class filter_scoreboard;
    logic [CFG_W-1:0]  ff_0_1;
    logic [CFG_W-1:0]  ff_2_3;
    logic [COEF_W-1:0] ff_4;
    logic [CFG_W-1:0]  fb_1_2;
    logic [CFG_W-1:0]  fb_3_4;
    sample_t           x_taps [MAX_ORDER];
    out_t              y_taps [MAX_ORDER];
    out_t              filtered_due [$];
    int                tap_limit;
    int unsigned       mismatches;

    function new(int filter_order);
      tap_limit  = filter_order;
      mismatches = 0;
      ff_0_1     = RST_FF_COEF_0_1;
      ff_2_3     = RST_FF_COEF_2_3;
      ff_4       = RST_FF_COEF_4;
      fb_1_2     = RST_FB_COEF_1_2;
      fb_3_4     = RST_FB_COEF_3_4;
      clear_taps();
    endfunction

    function void clear_taps();
      foreach (x_taps[i]) begin
        x_taps[i] = '0;
        y_taps[i] = '0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FF_COEF_0_1: ff_0_1 = data;
        REG_FF_COEF_2_3: ff_2_3 = data;
        REG_FF_COEF_4:   ff_4   = data[COEF_W-1:0];
        REG_FB_COEF_1_2: fb_1_2 = data;
        REG_FB_COEF_3_4: fb_3_4 = data;
        default: ;
      endcase
    endfunction

    // Exact accumulate, round half up, floor-scale, saturate, then shift the histories.
    function out_t next_filtered(sample_t x0);
      coef_t  b [MAX_ORDER+1];
      coef_t  a [MAX_ORDER+1];
      longint acc;
      longint q;
      out_t   y0;
      b[0] = ff_0_1[15:0];
      b[1] = ff_0_1[31:16];
      b[2] = ff_2_3[15:0];
      b[3] = ff_2_3[31:16];
      b[4] = ff_4;
      a[0] = '0;
      a[1] = fb_1_2[15:0];
      a[2] = fb_1_2[31:16];
      a[3] = fb_3_4[15:0];
      a[4] = fb_3_4[31:16];
      acc = longint'(b[0]) * longint'(x0);
      for (int k = 1; k <= MAX_ORDER; k++) begin
        if (k <= tap_limit) begin
          acc += longint'(b[k]) * longint'(x_taps[k-1]);
          acc -= longint'(a[k]) * longint'(y_taps[k-1]);
        end
      end
      acc += longint'(1) << (COEF_FRAC_BITS - 1);
      q = acc >>> COEF_FRAC_BITS;
      if (q > longint'(OUT_MAX)) begin
        y0 = OUT_MAX;
      end else if (q < longint'(OUT_MIN)) begin
        y0 = OUT_MIN;
      end else begin
        y0 = out_t'(q);
      end
      for (int k = MAX_ORDER - 1; k > 0; k--) begin
        x_taps[k] = x_taps[k-1];
        y_taps[k] = y_taps[k-1];
      end
      x_taps[0] = x0;
      y_taps[0] = y0;
      return y0;
    endfunction

    function void note_accepted_sample(logic kind, sample_t value);
      if (kind == KIND_CLEAR) begin
        clear_taps();
      end else begin
        filtered_due.push_back(next_filtered(value));
      end
    endfunction

    function void check_filtered_out(out_t got);
      out_t want;
      if (filtered_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $error("filtered_out: expected no transaction, got %0d", got);
      end else begin
        want = filtered_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("filtered_out: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int outstanding();
      return filtered_due.size();
    endfunction

  endclass

endpackage

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for iir_direct_form_one_filter_unit: drives the sample channel
// and coefficient port, and checks every filtered output against filter_check_pkg.
// Depends on iirdf1_pkg, the channel interfaces and filter_check_pkg.
module testbench;
  import iirdf1_pkg::*;
  import filter_check_pkg::*;

  localparam int FILTER_ORDER    = 4;
  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int NUM_COEF_REGS   = 5;
  // Results are registered in the output queue; the settle pause covers a clear still
  // in flight and the two-entry output queue.
  localparam int SETTLE_CYCLES   = 6;
  localparam int TAIL_CYCLES     = 10;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 100;
  // Longest correct quiet stretch is a sender gap plus a receiver stall plus a settle pause.
  localparam int WATCHDOG_LIMIT  = 1000;

  localparam logic [CFG_IDX_W-1:0] COEF_REGS [NUM_COEF_REGS] = '{
    REG_FF_COEF_0_1, REG_FF_COEF_2_3, REG_FF_COEF_4, REG_FB_COEF_1_2, REG_FB_COEF_3_4
  };

  typedef logic [CFG_W-1:0] coef_bank_t [NUM_COEF_REGS];

  // Coefficient sets that the phases move through.
  typedef enum int {
    SET_DEFAULT,
    SET_FULL_RANDOM,
    SET_GENTLE,
    SET_LOWER_ORDER,
    SET_EXTREME_UP,
    SET_EXTREME_DOWN,
    SET_ZERO
  } coef_setting_e;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  iirdf1_sample_if samples_ch();
  iirdf1_result_if results_ch();

  filter_scoreboard sb;

  // Idling knobs, in percent per transaction or per cycle; set per phase.
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  iir_direct_form_one_filter_unit #(
    .ORDER(FILTER_ORDER)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_ch),
    .results  (results_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Receiver side: ready drops in random bursts. Once stall_pct is
  // zero, a burst already running finishes and ready then stays high.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!rst && stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
      results_ch.ready <= 1'b0;
      stall_left       <= $urandom_range(4, 0);
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  // Observe every transaction at the rising edge. The sample is noted before the
  // result is checked so that the order within one edge never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write)
        sb.write_register(cfg_index, cfg_data);
      if (samples_ch.valid && samples_ch.ready)
        sb.note_accepted_sample(samples_ch.kind, samples_ch.sample_in);
      if (results_ch.valid && results_ch.ready)
        sb.check_filtered_out(results_ch.filtered_out);
    end
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if (rst || cfg_write || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A random coefficient in [-span, span].
  function automatic coef_t small_coef(int span);
    return coef_t'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  function automatic coef_bank_t build_setting(coef_setting_e mode);
    coef_bank_t bank;
    coef_t      b [NUM_COEF_REGS];
    coef_t      a [NUM_COEF_REGS];
    int         keep;
    keep = $urandom_range(3, 1);
    for (int i = 0; i < NUM_COEF_REGS; i++) begin
      case (mode)
        SET_FULL_RANDOM: begin
          b[i] = coef_t'($urandom);
          a[i] = coef_t'($urandom);
        end
        SET_GENTLE: begin
          // Feedback sums stay well under one, so the filter is stable.
          b[i] = small_coef(2047);
          a[i] = small_coef(1023);
        end
        SET_LOWER_ORDER: begin
          // Taps above the chosen order are zero, as a lower-order design would be.
          b[i] = (i <= keep) ? small_coef(4095) : coef_t'(0);
          a[i] = (i <= keep) ? small_coef(2047) : coef_t'(0);
        end
        SET_EXTREME_UP: begin
          // Largest gain with positive feedback: the output runs into saturation.
          b[i] = 16'sh7FFF;
          a[i] = 16'sh8000;
        end
        SET_EXTREME_DOWN: begin
          b[i] = 16'sh8000;
          a[i] = 16'sh7FFF;
        end
        default: begin
          b[i] = '0;
          a[i] = '0;
        end
      endcase
    end
    bank[0] = {b[1], b[0]};
    bank[1] = {b[3], b[2]};
    // The fifth feed-forward register is 16 bits wide; random upper bits must be dropped.
    bank[2] = (mode == SET_FULL_RANDOM) ? {16'($urandom), b[4]} : {{16{b[4][15]}}, b[4]};
    bank[3] = {a[2], a[1]};
    bank[4] = {a[4], a[3]};
    if (mode == SET_DEFAULT) begin
      bank[0] = RST_FF_COEF_0_1;
      bank[1] = RST_FF_COEF_2_3;
      bank[2] = CFG_W'(RST_FF_COEF_4);
      bank[3] = RST_FB_COEF_1_2;
      bank[4] = RST_FB_COEF_3_4;
    end
    return bank;
  endfunction

  // Full-range noise half the time, else ECG-sized values or the rails.
  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(9, 0))
      0:       s = 16'sh7FFF;
      1:       s = 16'sh8000;
      2, 3, 4: s = sample_t'(int'($urandom_range(511, 0)) - 256);
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  // Valid stays high so that transactions can run back to back.
  task automatic push_item(input logic kind, input sample_t value);
    if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(negedge clk);
    end
    samples_ch.valid     <= 1'b1;
    samples_ch.kind      <= kind;
    samples_ch.sample_in <= value;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
  endtask

  task automatic push_run(input logic kind, input sample_t value, input int count);
    repeat (count) push_item(kind, value);
  endtask

  // Stop sending and wait for every due output, then let a trailing clear settle.
  task automatic drain_results();
    samples_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register per cycle; the histories are kept across the change.
  task automatic load_coefs(input coef_bank_t bank, input bit also_unused);
    for (int i = 0; i < NUM_COEF_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= COEF_REGS[i];
      cfg_data  <= bank[i];
      @(negedge clk);
    end
    // Indexes past the last register must leave every coefficient alone.
    if (also_unused) begin
      for (int u = REG_FB_COEF_3_4 + 1; u < 2 ** CFG_IDX_W; u++) begin
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_W'(u);
        cfg_data  <= $urandom;
        @(negedge clk);
      end
    end
    cfg_write <= 1'b0;
  endtask

  function automatic int unsigned pick_pct();
    int unsigned p;
    case ($urandom_range(3, 0))
      0:       p = 0;
      1:       p = 10;
      2:       p = 30;
      default: p = 60;
    endcase
    return p;
  endfunction

  initial begin
    coef_setting_e mode;
    bit            last_phase;
    logic          kind;

    sb                   = new(FILTER_ORDER);
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    samples_ch.valid     = 1'b0;
    samples_ch.kind      = KIND_SAMPLE;
    samples_ch.sample_in = '0;
    results_ch.ready     = 1'b1;
    gap_pct              = 0;
    stall_pct            = 0;
    stall_left           = 0;
    quiet_cycles         = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, default band-pass from reset: input rails, zero, one and minus
    // one, and a clear whose sample field must be ignored.
    gap_pct   = 20;
    stall_pct = 20;
    push_item(KIND_SAMPLE, 16'sh7FFF);
    push_item(KIND_SAMPLE, 16'sh8000);
    push_item(KIND_SAMPLE, 16'sh0000);
    push_item(KIND_SAMPLE, 16'sh0001);
    push_item(KIND_SAMPLE, 16'shFFFF);
    push_item(KIND_SAMPLE, 16'sh7FFF);
    push_item(KIND_CLEAR,  16'sh7FFF);
    push_item(KIND_SAMPLE, 16'sh8000);

    // Largest gain with positive feedback drives the output to the positive rail,
    // then after a clear to the negative one. Unused indexes are written here too.
    drain_results();
    load_coefs(build_setting(SET_EXTREME_UP), 1'b1);
    push_run(KIND_SAMPLE, 16'sh7FFF, 4);
    push_item(KIND_CLEAR, 16'sh8000);
    push_run(KIND_SAMPLE, 16'sh8000, 4);

    // Opposite signs everywhere: the feedback alternates and saturates both ways.
    drain_results();
    load_coefs(build_setting(SET_EXTREME_DOWN), 1'b0);
    push_run(KIND_SAMPLE, 16'sh7FFF, 3);

    // All coefficients zero: the output is zero whatever the histories hold.
    drain_results();
    load_coefs(build_setting(SET_ZERO), 1'b0);
    push_item(KIND_SAMPLE, 16'sh8000);
    push_item(KIND_SAMPLE, 16'sh7FFF);

    // Random part. Each phase starts idle with a new coefficient set; the histories
    // carry across the change. The last phase runs with no idling on either side.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      last_phase = (phase == RANDOM_PHASES - 1);
      drain_results();
      mode = coef_setting_e'($urandom_range(SET_ZERO, SET_DEFAULT));
      load_coefs(build_setting(mode), 1'b0);
      if (last_phase) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then the sender holds off until the output side is empty.
        if (!last_phase && $urandom_range(99, 0) == 0)
          drain_results();
        kind = ($urandom_range(24, 0) == 0) ? KIND_CLEAR : KIND_SAMPLE;
        push_item(kind, pick_sample());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### iir_direct_form_one_filter_unit.f
design/iirdf1_pkg.sv
design/iirdf1_channels.sv
design/iirdf1_cell.sv
design/iirdf1_skid.sv
design/iir_direct_form_one_filter_unit.sv
design/iirdf1_checker.sv
tb/filter_check_pkg.sv
tb/testbench.sv
